// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions clocked on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When pre holds at one edge, post must hold at the next edge.
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: hdl/ycc_pkg.sv
// ----------------------------------------------------------------------------
// ycc_pkg
// Types and fixed constants shared by the color conversion pipeline.
// ----------------------------------------------------------------------------
package ycc_pkg;

	// Pixel component width and the signed operand width after offset removal.
	localparam int PIX_W = 8;
	localparam int OP_W  = PIX_W + 1;

	// Extra bits over the fraction width for coefficients, products and sums.
	localparam int COEF_XTRA = 3;
	localparam int PROD_XTRA = COEF_XTRA + OP_W;
	localparam int SUM_XTRA  = PROD_XTRA + 2;

	// Matrix coefficients in units of 1e-5.
	localparam longint K_SCALE = 100000;
	localparam longint K_ROUND = 50000;
	localparam longint K_YR    = 29900;
	localparam longint K_YG    = 58700;
	localparam longint K_YB    = 11400;
	localparam longint K_CBR   = 16870;
	localparam longint K_CBG   = 33130;
	localparam longint K_CRG   = 41870;
	localparam longint K_CRB   = 8130;
	localparam longint K_RCR   = 140200;
	localparam longint K_GCB   = 34414;
	localparam longint K_GCR   = 71414;
	localparam longint K_BCB   = 177200;

	// Chroma offset applied in the forward direction.
	localparam longint CHROMA_OFFSET = 128;

	// Register map.
	localparam int   REG_IDX_W     = 1;
	localparam logic REG_DIRECTION = 1'b0;

	// Direction codes.
	localparam logic DIR_RGB2YCC = 1'b0;
	localparam logic DIR_YCC2RGB = 1'b1;

	typedef logic signed [OP_W-1:0] op_t;
	typedef logic [PIX_W-1:0] pix_t;

	// Control that travels with each item down the pipeline.
	typedef struct packed {
		logic valid;
		logic dir;
	} ycc_ctl_t;

endpackage

// File: hdl/ycc_operand.sv
// ----------------------------------------------------------------------------
// ycc_operand
// Stage 1: captures an item and forms signed operands for the matrix.
// ----------------------------------------------------------------------------
module ycc_operand (
	input  logic             clk,
	input  logic             arst_n,
	input  ycc_pkg::ycc_ctl_t ctl_in,
	input  ycc_pkg::pix_t    pix_a,
	input  ycc_pkg::pix_t    pix_b,
	input  ycc_pkg::pix_t    pix_c,
	output logic             in_ready,
	output ycc_pkg::ycc_ctl_t ctl_s1,
	output ycc_pkg::op_t     op_s1 [3],
	input  logic             out_ready
);
	import ycc_pkg::*;

	op_t op_c [3];

	// In the inverse direction the chroma inputs lose their offset of 128,
	// which is an inversion of the top bit followed by sign extension.
	always_comb begin
		op_c[0] = op_t'({1'b0, pix_a});
		if (ctl_in.dir == DIR_YCC2RGB) begin
			op_c[1] = op_t'({~pix_b[PIX_W-1], ~pix_b[PIX_W-1], pix_b[PIX_W-2:0]});
			op_c[2] = op_t'({~pix_c[PIX_W-1], ~pix_c[PIX_W-1], pix_c[PIX_W-2:0]});
		end else begin
			op_c[1] = op_t'({1'b0, pix_b});
			op_c[2] = op_t'({1'b0, pix_c});
		end
	end

	assign in_ready = !ctl_s1.valid || out_ready;

	// Stage control advances whenever the stage can hand its item on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (in_ready) begin
			ctl_s1 <= ctl_in;
		end
	end

	// Operand payload is loaded only with a new item.
	always_ff @(posedge clk) begin
		if (in_ready && ctl_in.valid) begin
			op_s1 <= op_c;
		end
	end

endmodule

// File: hdl/ycc_mult.sv
// ----------------------------------------------------------------------------
// ycc_mult
// Stage 2: nine fixed-point coefficient products, registered.
// ----------------------------------------------------------------------------
module ycc_mult #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ycc_pkg::ycc_ctl_t ctl_in,
	input  ycc_pkg::op_t     op_in [3],
	output logic             in_ready,
	output ycc_pkg::ycc_ctl_t ctl_s2,
	output logic signed [COEF_FRAC_BITS+ycc_pkg::PROD_XTRA-1:0] prod_s2 [3][3],
	input  logic             out_ready
);
	import ycc_pkg::*;

	localparam int CW = COEF_FRAC_BITS + COEF_XTRA;
	localparam int PW = COEF_FRAC_BITS + PROD_XTRA;

	// Coefficients rounded half up to COEF_FRAC_BITS fraction bits.
	localparam longint L_YR   = ((K_YR << COEF_FRAC_BITS) + K_ROUND) / K_SCALE;
	localparam longint L_YG   = ((K_YG << COEF_FRAC_BITS) + K_ROUND) / K_SCALE;
	localparam longint L_YB   = ((K_YB << COEF_FRAC_BITS) + K_ROUND) / K_SCALE;
	localparam longint L_CBR  = ((K_CBR << COEF_FRAC_BITS) + K_ROUND) / K_SCALE;
	localparam longint L_CBG  = ((K_CBG << COEF_FRAC_BITS) + K_ROUND) / K_SCALE;
	localparam longint L_CRG  = ((K_CRG << COEF_FRAC_BITS) + K_ROUND) / K_SCALE;
	localparam longint L_CRB  = ((K_CRB << COEF_FRAC_BITS) + K_ROUND) / K_SCALE;
	localparam longint L_RCR  = ((K_RCR << COEF_FRAC_BITS) + K_ROUND) / K_SCALE;
	localparam longint L_GCB  = ((K_GCB << COEF_FRAC_BITS) + K_ROUND) / K_SCALE;
	localparam longint L_GCR  = ((K_GCR << COEF_FRAC_BITS) + K_ROUND) / K_SCALE;
	localparam longint L_BCB  = ((K_BCB << COEF_FRAC_BITS) + K_ROUND) / K_SCALE;
	localparam longint L_ONE  = longint'(1) << COEF_FRAC_BITS;
	localparam longint L_HALF = longint'(1) << (COEF_FRAC_BITS - 1);

	logic signed [CW-1:0] coef [3][3];
	logic signed [PW-1:0] prod_c [3][3];

	// Matrix selection for the item at the stage input.
	always_comb begin
		if (ctl_in.dir == DIR_YCC2RGB) begin
			coef[0][0] = CW'(L_ONE);
			coef[0][1] = '0;
			coef[0][2] = CW'(L_RCR);
			coef[1][0] = CW'(L_ONE);
			coef[1][1] = CW'(-L_GCB);
			coef[1][2] = CW'(-L_GCR);
			coef[2][0] = CW'(L_ONE);
			coef[2][1] = CW'(L_BCB);
			coef[2][2] = '0;
		end else begin
			coef[0][0] = CW'(L_YR);
			coef[0][1] = CW'(L_YG);
			coef[0][2] = CW'(L_YB);
			coef[1][0] = CW'(-L_CBR);
			coef[1][1] = CW'(-L_CBG);
			coef[1][2] = CW'(L_HALF);
			coef[2][0] = CW'(L_HALF);
			coef[2][1] = CW'(-L_CRG);
			coef[2][2] = CW'(-L_CRB);
		end
	end

	// Nine independent signed products; each fits PW bits exactly.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				prod_c[j][k] = PW'(coef[j][k]) * PW'(op_in[k]);
			end
		end
	end

	assign in_ready = !ctl_s2.valid || out_ready;

	// Stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (in_ready) begin
			ctl_s2 <= ctl_in;
		end
	end

	// Product payload.
	always_ff @(posedge clk) begin
		if (in_ready && ctl_in.valid) begin
			prod_s2 <= prod_c;
		end
	end

endmodule

// File: hdl/ycc_accum.sv
// ----------------------------------------------------------------------------
// ycc_accum
// Stage 3: sums each product row with its rounding bias and any chroma offset.
// ----------------------------------------------------------------------------
module ycc_accum #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ycc_pkg::ycc_ctl_t ctl_in,
	input  logic signed [COEF_FRAC_BITS+ycc_pkg::PROD_XTRA-1:0] prod_in [3][3],
	output logic             in_ready,
	output ycc_pkg::ycc_ctl_t ctl_s3,
	output logic signed [COEF_FRAC_BITS+ycc_pkg::SUM_XTRA-1:0] sum_s3 [3],
	input  logic             out_ready
);
	import ycc_pkg::*;

	localparam int SW = COEF_FRAC_BITS + SUM_XTRA;

	// Half an LSB for round half up, plus the chroma offset where it applies.
	localparam logic signed [SW-1:0] B_HALF =
		SW'(longint'(1) << (COEF_FRAC_BITS - 1));
	localparam logic signed [SW-1:0] B_OFFS =
		SW'((CHROMA_OFFSET << COEF_FRAC_BITS) + (longint'(1) << (COEF_FRAC_BITS - 1)));

	logic signed [SW-1:0] bias [3];
	logic signed [SW-1:0] sum_c [3];

	// Row bias depends on the direction of the item.
	always_comb begin
		bias[0] = B_HALF;
		if (ctl_in.dir == DIR_RGB2YCC) begin
			bias[1] = B_OFFS;
			bias[2] = B_OFFS;
		end else begin
			bias[1] = B_HALF;
			bias[2] = B_HALF;
		end
	end

	// Row sums, exact in SW bits.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sum_c[j] = SW'(prod_in[j][0]) + SW'(prod_in[j][1]) + SW'(prod_in[j][2])
				+ bias[j];
		end
	end

	assign in_ready = !ctl_s3.valid || out_ready;

	// Stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (in_ready) begin
			ctl_s3 <= ctl_in;
		end
	end

	// Sum payload.
	always_ff @(posedge clk) begin
		if (in_ready && ctl_in.valid) begin
			sum_s3 <= sum_c;
		end
	end

endmodule

// File: hdl/ycc_sat.sv
// ----------------------------------------------------------------------------
// ycc_sat
// Stage 4: drops the fraction, clamps to 0..255 and holds the output item.
// ----------------------------------------------------------------------------
module ycc_sat #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ycc_pkg::ycc_ctl_t ctl_in,
	input  logic signed [COEF_FRAC_BITS+ycc_pkg::SUM_XTRA-1:0] sum_in [3],
	output logic             in_ready,
	output ycc_pkg::ycc_ctl_t ctl_s4,
	output ycc_pkg::pix_t    pix_s4 [3],
	input  logic             out_ready
);
	import ycc_pkg::*;

	localparam int SW = COEF_FRAC_BITS + SUM_XTRA;

	pix_t pix_c [3];

	// Negative sums clamp to zero, anything at or above 256 clamps to 255.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (sum_in[j][SW-1]) begin
				pix_c[j] = '0;
			end else if (|sum_in[j][SW-2:COEF_FRAC_BITS+PIX_W]) begin
				pix_c[j] = '1;
			end else begin
				pix_c[j] = sum_in[j][COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
			end
		end
	end

	assign in_ready = !ctl_s4.valid || out_ready;

	// Output control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (in_ready) begin
			ctl_s4 <= ctl_in;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (in_ready && ctl_in.valid) begin
			pix_s4 <= pix_c;
		end
	end

endmodule

// File: hdl/rgb_ycbcr_color_convert.sv
// An accepted item passes in turn through the operand, product, sum and output
// stage registers, and is offered on the output from the last of them.
// Throughput: one item per cycle; each of the four stages holds one item and
// stalls only when its successor is full and the output is not taken.
// Reset: arst_n clears the stage valid bits and sets direction to RGB to YCbCr.
// ----------------------------------------------------------------------------
// rgb_ycbcr_color_convert
// Full-range BT.601 RGB to YCbCr and YCbCr to RGB converter with an APB-style
// direction register and a four-stage valid/ready pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_ycbcr_color_convert #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input item.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_r_or_y,
	input  logic [7:0]  in_g_or_cb,
	input  logic [7:0]  in_b_or_cr,
	// Result item.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_y_or_r,
	output logic [7:0]  out_cb_or_g,
	output logic [7:0]  out_cr_or_b
);
	import ycc_pkg::*;

	localparam int PW = COEF_FRAC_BITS + PROD_XTRA;
	localparam int SW = COEF_FRAC_BITS + SUM_XTRA;

	logic                 direction_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;
	logic                 dir_wr;

	ycc_ctl_t             ctl_in;
	ycc_ctl_t             ctl_s1;
	ycc_ctl_t             ctl_s2;
	ycc_ctl_t             ctl_s3;
	ycc_ctl_t             ctl_s4;
	op_t                  op_s1 [3];
	logic signed [PW-1:0] prod_s2 [3][3];
	logic signed [SW-1:0] sum_s3 [3];
	pix_t                 pix_s4 [3];
	logic                 mult_ready;
	logic                 accum_ready;
	logic                 sat_ready;

	// Register access decode.
	assign reg_idx = paddr[2 +: REG_IDX_W];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign dir_wr  = cfg_wr && reg_idx == REG_DIRECTION;
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_DIRECTION) ? {31'b0, direction_q} : '0;

	// Direction register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_RGB2YCC;
		end else if (dir_wr) begin
			direction_q <= pwdata[0];
		end
	end

	// Each item takes the direction in force when it is accepted.
	assign ctl_in = '{valid: in_valid, dir: direction_q};

	ycc_operand u_operand (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_in),
		.pix_a     (in_r_or_y),
		.pix_b     (in_g_or_cb),
		.pix_c     (in_b_or_cr),
		.in_ready  (in_ready),
		.ctl_s1    (ctl_s1),
		.op_s1     (op_s1),
		.out_ready (mult_ready)
	);

	ycc_mult #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_s1),
		.op_in     (op_s1),
		.in_ready  (mult_ready),
		.ctl_s2    (ctl_s2),
		.prod_s2   (prod_s2),
		.out_ready (accum_ready)
	);

	ycc_accum #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_s2),
		.prod_in   (prod_s2),
		.in_ready  (accum_ready),
		.ctl_s3    (ctl_s3),
		.sum_s3    (sum_s3),
		.out_ready (sat_ready)
	);

	ycc_sat #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_s3),
		.sum_in    (sum_s3),
		.in_ready  (sat_ready),
		.ctl_s4    (ctl_s4),
		.pix_s4    (pix_s4),
		.out_ready (out_ready)
	);

	// Result item.
	assign out_valid   = ctl_s4.valid;
	assign out_y_or_r  = pix_s4[0];
	assign out_cb_or_g = pix_s4[1];
	assign out_cr_or_b = pix_s4[2];

	// A taken output must leave every stage free to advance.
	`ASSERT_ALWAYS(a_ready_chain, !out_ready || in_ready, "ready chain broken with output taken")
	// An item leaving the last arithmetic stage must appear at the output.
	`ASSERT_NEXT(a_last_stage, ctl_s3.valid && sat_ready, out_valid, "item lost before output")
	// A direction write takes effect at the next edge.
	`ASSERT_NEXT(a_dir_write, dir_wr, direction_q == $past(pwdata[0]), "direction write not taken")

endmodule
